FILE: rtl/tvas_pkg.sv
// ----------------------------------------------------------------------------
// tvas_pkg
// Shared types, constants and helpers for the triangle vertex axis sort.
// ----------------------------------------------------------------------------
package tvas_pkg;

	localparam int unsigned COORD_WIDTH = 32;
	localparam int unsigned NUM_VERTS   = 3;
	localparam int unsigned NUM_LANES   = 3;
	localparam int unsigned RANK_W      = 2;
	localparam int unsigned STATUS_W    = 2;

	// vertex words packed without gaps, padded to whole bytes
	localparam int unsigned VERT_BITS = 2 * COORD_WIDTH * NUM_VERTS;
	localparam int unsigned TDATA_W   = ((VERT_BITS + 7) / 8) * 8;

	localparam logic OP_SORT_Y = 1'b0;
	localparam logic OP_SORT_X = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_SORTED     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_TOP_TIE    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd2;

	// vertex pair handled by each lane
	localparam int unsigned LANE_A [NUM_LANES] = '{0, 1, 0};
	localparam int unsigned LANE_B [NUM_LANES] = '{1, 2, 2};

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t y;
		coord_t x;
	} vertex_t;

	typedef vertex_t [NUM_VERTS-1:0] vert_set_t;

	typedef struct packed {
		logic ge;      // key of a >= key of b, so a stays ahead of b
		logic key_eq;
		logic x_eq;
		logic y_eq;
	} pair_flags_t;

	typedef pair_flags_t [NUM_LANES-1:0] lane_flags_t;

	function automatic coord_t sort_key(input vertex_t v, input logic op);
		return (op == OP_SORT_X) ? v.x : v.y;
	endfunction

endpackage

FILE: rtl/tvas_lane.sv
// ----------------------------------------------------------------------------
// tvas_lane
// Compares one pair of vertices: key order and coordinate equality.
// ----------------------------------------------------------------------------
module tvas_lane
	import tvas_pkg::*;
(
	input  logic        opcode,
	input  vertex_t     vert_a,
	input  vertex_t     vert_b,
	output pair_flags_t flags
);

	coord_t key_a;
	coord_t key_b;

	always_comb begin
		key_a = sort_key(vert_a, opcode);
		key_b = sort_key(vert_b, opcode);
		flags.ge     = (key_a >= key_b);
		flags.key_eq = (key_a == key_b);
		flags.x_eq   = (vert_a.x == vert_b.x);
		flags.y_eq   = (vert_a.y == vert_b.y);
	end

endmodule

FILE: rtl/tvas_merge.sv
// ----------------------------------------------------------------------------
// tvas_merge
// Combines the pair results into ranks, picks the vertex for each slot and
// forms the status.
// ----------------------------------------------------------------------------
module tvas_merge
	import tvas_pkg::*;
(
	input  lane_flags_t         flags,
	input  vert_set_t           verts,
	output vert_set_t           sorted,
	output logic [STATUS_W-1:0] status
);

	logic [RANK_W-1:0] rank [NUM_VERTS];
	logic              degen;
	logic              tie;
	logic              g01;
	logic              g12;
	logic              g02;

	always_comb begin
		g01 = flags[0].ge;
		g12 = flags[1].ge;
		g02 = flags[2].ge;

		degen = (flags[0].y_eq & flags[1].y_eq) |
			(flags[0].x_eq & flags[1].x_eq) |
			(flags[0].x_eq & flags[0].y_eq) |
			(flags[1].x_eq & flags[1].y_eq) |
			(flags[2].x_eq & flags[2].y_eq);

		// stable descending order: lower index wins ties
		rank[0] = RANK_W'(!g01) + RANK_W'(!g02);
		rank[1] = RANK_W'(g01)  + RANK_W'(!g12);
		rank[2] = RANK_W'(g02)  + RANK_W'(g12);

		sorted = '0;
		for (int s = 0; s < NUM_VERTS; s++) begin
			for (int v = 0; v < NUM_VERTS; v++) begin
				if (rank[v] == RANK_W'(s)) begin
					sorted[s] = sorted[s] | verts[v];
				end
			end
		end

		tie = 1'b0;
		for (int l = 0; l < NUM_LANES; l++) begin
			if (flags[l].key_eq &&
			    ((rank[LANE_A[l]] == RANK_W'(0) && rank[LANE_B[l]] == RANK_W'(1)) ||
			     (rank[LANE_A[l]] == RANK_W'(1) && rank[LANE_B[l]] == RANK_W'(0)))) begin
				tie = 1'b1;
			end
		end

		if (degen) begin
			sorted = verts;
			status = STATUS_DEGENERATE;
		end else if (tie) begin
			status = STATUS_TOP_TIE;
		end else begin
			status = STATUS_SORTED;
		end
	end

endmodule

FILE: rtl/triangle_vertex_axis_sort.sv
// ----------------------------------------------------------------------------
// triangle_vertex_axis_sort
// Sorts three vertices by y or x, rejecting degenerate triangles.
// ----------------------------------------------------------------------------
// One triangle is taken every clock while the pipeline has room: the first
// stage registers three pairwise compare lanes, the second stage registers
// the merged status and the selected vertices. Each stage holds its word
// while the next one is full and cannot pass its word on, so a stalled output
// only blocks the input once both stages are occupied. Opcode 0 sorts by y, 1
// by x, in descending signed order; equal keys keep their input order. Degenerate
// triangles (all y equal, all x equal, or two coincident vertices) pass
// through unchanged with status 2.
module triangle_vertex_axis_sort
	import tvas_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// first_x, first_y, second_x, second_y, third_x, third_y, zero pad
	input  logic [TDATA_W-1:0]  s_axis_tdata,
	// opcode
	input  logic [0:0]          s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// top_x, top_y, middle_x, middle_y, bottom_x, bottom_y, zero pad
	output logic [TDATA_W-1:0]  m_axis_tdata,
	// status
	output logic [STATUS_W-1:0] m_axis_tuser
);

	vert_set_t           in_verts;
	lane_flags_t         lane_flags;
	vert_set_t           merged;
	logic [STATUS_W-1:0] merged_status;

	logic                valid_s1;
	vert_set_t           verts_s1;
	lane_flags_t         flags_s1;
	logic                op_s1;

	logic                valid_s2;
	vert_set_t           verts_s2;
	logic [STATUS_W-1:0] status_s2;
	logic                op_s2;

	logic                load_s1;
	logic                load_s2;

	always_comb begin
		for (int v = 0; v < NUM_VERTS; v++) begin
			in_verts[v].x = s_axis_tdata[2*v*COORD_WIDTH +: COORD_WIDTH];
			in_verts[v].y = s_axis_tdata[(2*v+1)*COORD_WIDTH +: COORD_WIDTH];
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		tvas_lane u_lane (
			.opcode (s_axis_tuser[0]),
			.vert_a (in_verts[LANE_A[l]]),
			.vert_b (in_verts[LANE_B[l]]),
			.flags  (lane_flags[l])
		);
	end

	tvas_merge u_merge (
		.flags  (flags_s1),
		.verts  (verts_s1),
		.sorted (merged),
		.status (merged_status)
	);

	assign load_s2       = !valid_s2 || m_axis_tready;
	assign load_s1       = !valid_s1 || load_s2;
	assign s_axis_tready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			verts_s1 <= in_verts;
			flags_s1 <= lane_flags;
			op_s1    <= s_axis_tuser[0];
		end
		if (load_s2) begin
			verts_s2  <= merged;
			status_s2 <= merged_status;
			op_s2     <= op_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = TDATA_W'(verts_s2);
	assign m_axis_tuser  = status_s2;

	// sorted words come out in non-increasing key order
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status_s2 != STATUS_DEGENERATE |->
			sort_key(verts_s2[0], op_s2) >= sort_key(verts_s2[1], op_s2) &&
			sort_key(verts_s2[1], op_s2) >= sort_key(verts_s2[2], op_s2))
		else $error("sorted vertices out of order");

	// tie status agrees with the top two keys
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status_s2 != STATUS_DEGENERATE |->
			((status_s2 == STATUS_TOP_TIE) ==
			 (sort_key(verts_s2[0], op_s2) == sort_key(verts_s2[1], op_s2))))
		else $error("top tie status wrong");

	// input stalls only when both stages hold words and the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && m_axis_tvalid && !m_axis_tready)
		else $error("input stalled with room in the pipeline");

	// a word in the first stage reaches the output register in the next cycle when the output drains
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_axis_tready |=> m_axis_tvalid)
		else $error("first stage word lost");

endmodule

FILE: tb/triangle_vertex_axis_sort_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_vertex_axis_sort_tb
// Self-checking bench for the triangle vertex axis sort.
// A scoreboard predicts each sorted triangle when its input word is taken and
// compares the output words field by field, in order. A directed set covers
// ties, the degenerate forms and the coordinate extremes under both keys.
// Random triangles follow, with random gaps on both sides, one long output
// stall and one pause until the pipeline has drained.
// ----------------------------------------------------------------------------
module triangle_vertex_axis_sort_tb
	import tvas_pkg::*;
();

	localparam int unsigned RANDOM_ITEMS  = 800;
	localparam int unsigned HOLD_CYCLES   = 60;
	localparam int unsigned IDLE_LIMIT    = 1000;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned DIRECTED_TRIS = 12;

	localparam coord_t C_MAX = 32'sh7fff_ffff;
	localparam coord_t C_MIN = 32'sh8000_0000;

	// x0, y0, x1, y1, x2, y2
	localparam coord_t DIRECTED_SET [DIRECTED_TRIS][6] = '{
		'{0, 10, 5, 30, 9, 20},
		'{0, 1, 1, 2, 2, 3},
		'{0, 7, 4, 7, 9, 7},
		'{3, 1, 3, 8, 3, -5},
		'{2, 2, 2, 2, 6, 9},
		'{1, 5, 4, 6, 4, 6},
		'{-3, 4, 8, 1, -3, 4},
		'{0, 30, 5, 30, 9, 10},
		'{7, 30, 7, 10, 2, 10},
		'{C_MAX, C_MIN, C_MIN, C_MAX, 0, 0},
		'{-1, -65536, 65536, -1, C_MIN, 1},
		'{C_MAX, C_MAX, C_MIN, C_MIN, -1, 0}
	};

	class sort_scoreboard;
		typedef struct {
			vert_set_t      verts;
			logic [STATUS_W-1:0] status;
		} sorted_t;

		sorted_t sorted_q[$];
		int      errors;
		string   field_names[6] = '{"top_x", "top_y", "middle_x", "middle_y",
			"bottom_x", "bottom_y"};

		function int pending();
			return sorted_q.size();
		endfunction

		// predicts the sorted triangle for one accepted input word
		function void note_triangle(logic op, logic [TDATA_W-1:0] data);
			sorted_t   entry;
			vert_set_t vs;
			vertex_t   tmp;
			coord_t    ka, kb;
			logic      by_x, degenerate;
			int        lo;
			vs = data[VERT_BITS-1:0];
			by_x = (op == OP_SORT_X);
			degenerate = (vs[0].y == vs[1].y && vs[1].y == vs[2].y) ||
				(vs[0].x == vs[1].x && vs[1].x == vs[2].x) ||
				vs[0] == vs[1] || vs[1] == vs[2] || vs[0] == vs[2];
			if (degenerate) begin
				entry.status = STATUS_DEGENERATE;
			end else begin
				// compare-and-swap on pairs (0,1), (1,2), (0,1), strict less-than only
				for (int s = 0; s < 3; s++) begin
					lo = (s == 1) ? 1 : 0;
					ka = by_x ? vs[lo].x : vs[lo].y;
					kb = by_x ? vs[lo+1].x : vs[lo+1].y;
					if (ka < kb) begin
						tmp       = vs[lo];
						vs[lo]    = vs[lo+1];
						vs[lo+1]  = tmp;
					end
				end
				ka = by_x ? vs[0].x : vs[0].y;
				kb = by_x ? vs[1].x : vs[1].y;
				entry.status = (ka == kb) ? STATUS_TOP_TIE : STATUS_SORTED;
			end
			entry.verts = vs;
			sorted_q.push_back(entry);
		endfunction

		function void check_result(logic [TDATA_W-1:0] data, logic [STATUS_W-1:0] status);
			sorted_t   want;
			vert_set_t got_v;
			coord_t    want_c, got_c;
			if (sorted_q.size() == 0) begin
				$error("result word with no prediction waiting");
				errors++;
				return;
			end
			want  = sorted_q.pop_front();
			got_v = data[VERT_BITS-1:0];
			for (int i = 0; i < NUM_VERTS; i++) begin
				for (int a = 0; a < 2; a++) begin
					want_c = a ? want.verts[i].y : want.verts[i].x;
					got_c  = a ? got_v[i].y : got_v[i].x;
					if (got_c !== want_c) begin
						$error("%s: expected %0d, actual %0d", field_names[2*i+a],
							want_c, got_c);
						errors++;
					end
				end
			end
			if (status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, status);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [TDATA_W-1:0]  s_axis_tdata;
	logic [0:0]          s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic [STATUS_W-1:0] m_axis_tuser;

	sort_scoreboard board = new();
	bit             source_burst;
	bit             sink_burst;
	bit             hold_output;
	int unsigned    idle_cycles = 0;

	triangle_vertex_axis_sort DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [TDATA_W-1:0] pack_triangle(coord_t c [6]);
		vert_set_t vs;
		for (int i = 0; i < NUM_VERTS; i++) begin
			vs[i].x = c[2*i];
			vs[i].y = c[2*i+1];
		end
		return TDATA_W'(vs);
	endfunction

	function automatic coord_t pick_coord(int unsigned flavor);
		case (flavor)
			0: begin
				return coord_t'($urandom);
			end
			1: begin
				// small Q16.16 values, so ties and degenerate shapes come up often
				return coord_t'(int'($urandom_range(0, 6)) - 3) <<< 16;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return C_MAX;
					1: return C_MIN;
					2: return '0;
					3: return '1;
					default: return coord_t'(1);
				endcase
			end
		endcase
	endfunction

	task automatic send_triangle(input logic op, input logic [TDATA_W-1:0] data);
		int unsigned gap;
		gap = source_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_triangle(op, data);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic send_random_triangle();
		coord_t      c [6];
		int unsigned shape, flavor, src, dst;
		shape  = $urandom_range(0, 9);
		flavor = (shape < 5) ? 0 : (shape < 8) ? 1 : 2;
		for (int i = 0; i < 6; i++) c[i] = pick_coord(flavor);
		if (shape == 9) begin
			// force two vertices onto one point
			src = $urandom_range(0, 2);
			dst = (src + $urandom_range(1, 2)) % 3;
			c[2*dst]   = c[2*src];
			c[2*dst+1] = c[2*src+1];
		end
		send_triangle(logic'($urandom_range(0, 1)), pack_triangle(c));
	endtask

	// stimulus
	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_SORT_Y;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int t = 0; t < DIRECTED_TRIS; t++) begin
			send_triangle(OP_SORT_Y, pack_triangle(DIRECTED_SET[t]));
			send_triangle(OP_SORT_X, pack_triangle(DIRECTED_SET[t]));
		end
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) source_burst = ($urandom_range(0, 3) == 0);
			if (n == 300) begin
				// long output stall while words keep coming back to back
				hold_output  = 1'b1;
				source_burst = 1'b1;
			end
			if (n == 550) wait_drained();
			send_random_triangle();
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.errors == 0 && board.pending() == 0) begin
			$display("triangle_vertex_axis_sort: match");
		end else begin
			$display("triangle_vertex_axis_sort: mismatch");
		end
		$finish;
	end

	// result sink
	initial begin
		int unsigned gap;
		int unsigned results;
		m_axis_tready <= 1'b0;
		results = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_output) begin
				hold_output = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = sink_burst ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			board.check_result(m_axis_tdata, m_axis_tuser);
			results++;
			if (results % 50 == 0) sink_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("triangle_vertex_axis_sort: mismatch");
			$finish;
		end
	end

endmodule

FILE: filelist.f
rtl/tvas_pkg.sv
rtl/tvas_lane.sv
rtl/tvas_merge.sv
rtl/triangle_vertex_axis_sort.sv
tb/triangle_vertex_axis_sort_tb.sv
